// File: rtl/core/great_circle_distance_top_macros.svh
// Assertion helpers used by great_circle_distance_top.sv.
`ifndef GREAT_CIRCLE_DISTANCE_TOP_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/gcd_pkg.sv
`default_nettype none
package gcd_pkg;

    // CORDIC iteration count (12..32)
    localparam int CORDIC_STAGES = 24;
    // turn conversion (5 stages) + pre-rotation + iterations + output clamp
    localparam int ROT_LAT       = CORDIC_STAGES + 7;
    localparam int SQRT_STEPS    = 31;
    localparam int PIPE_LAT      = ROT_LAT + 37 + CORDIC_STAGES;

    typedef logic signed [39:0] t_turn_num;
    typedef logic signed [31:0] t_q30;
    typedef logic signed [33:0] t_cdc;

    // degrees*2^23 to binary angle: floor(m/45) mod 2^32 by exact division
    localparam logic [45:0] TURN_OFFSET = 46'd45 << 40;
    localparam logic [31:0] TURN_INV45  = 32'hA4FA4FA5;
    localparam logic [12:0] RECIP45     = 13'd5826;
    localparam int          RECIP_SH    = 18;

    localparam t_cdc GAIN_Q30 = 34'sd652032874;
    localparam t_cdc ONE_Q30  = 34'sd1073741824;

    localparam logic [31:0] DIST_MULT = 32'd2623417457;
    localparam logic [30:0] DIST_MAX  = 31'd1311708728;

    // atan(2^-i) in binary-angle units
    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
    };

endpackage
`default_nettype wire

// File: rtl/core/gcd_rot.sv
`default_nettype none
module gcd_rot (
    input  logic              i_clk,
    input  logic              i_en,
    input  gcd_pkg::t_turn_num i_num,
    output gcd_pkg::t_q30     o_sin,
    output gcd_pkg::t_q30     o_cos
);
    import gcd_pkg::*;

    logic [45:0] r_mp;
    logic [31:0] r_lo1, r_lo2, r_lo3, r_dnum, r_ang;
    logic [13:0] r_csum;
    logic [12:0] r_fold;
    logic [6:0]  r_q45;
    logic [12:0] fold;
    logic [5:0]  rem;
    t_cdc        z_pre;

    t_cdc r_cx [CORDIC_STAGES+1];
    t_cdc r_cy [CORDIC_STAGES+1];
    t_cdc r_cz [CORDIC_STAGES+1];
    logic r_flip [CORDIC_STAGES+1];

    t_cdc fx, fy;
    t_q30 r_sin, r_cos;

    function automatic t_q30 clamp_q30(input t_cdc v);
        if (v > ONE_Q30) begin
            return 32'(ONE_Q30);
        end else if (v < -ONE_Q30) begin
            return 32'(-ONE_Q30);
        end
        return 32'(v);
    endfunction

    // offset makes the numerator positive; its quotient is a multiple of 2^32
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mp  <= 46'(i_num) + TURN_OFFSET;
            r_lo1 <= i_num[31:0];
        end
    end

    // 2^12 = 1 mod 45: sum of 12-bit chunks keeps the residue
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_csum <= 14'(r_mp[11:0]) + 14'(r_mp[23:12]) + 14'(r_mp[35:24])
                      + 14'(r_mp[45:36]);
            r_lo2  <= r_lo1;
        end
    end

    // fold once more, then quotient by reciprocal
    assign fold = 13'(r_csum[11:0]) + 13'(r_csum[13:12]);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fold <= fold;
            r_q45  <= 7'((26'(fold) * 26'(RECIP45)) >> RECIP_SH);
            r_lo3  <= r_lo2;
        end
    end

    // remove residue so the division is exact
    assign rem = 6'(r_fold - 13'(13'(r_q45) * 13'd45));
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dnum <= r_lo3 - 32'(rem);
        end
    end

    // exact division by 45 modulo 2^32
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= 32'(r_dnum * TURN_INV45);
        end
    end

    // fold the angle into a half turn around zero
    assign z_pre = 34'($signed(r_ang));
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= GAIN_Q30;
            r_cy[0] <= '0;
            if (z_pre >= ONE_Q30) begin
                r_cz[0]   <= z_pre - (ONE_Q30 <<< 1);
                r_flip[0] <= 1'b1;
            end else if (z_pre < -ONE_Q30) begin
                r_cz[0]   <= z_pre + (ONE_Q30 <<< 1);
                r_flip[0] <= 1'b1;
            end else begin
                r_cz[0]   <= z_pre;
                r_flip[0] <= 1'b0;
            end
        end
    end

    // rotation iterations, one per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_it
        localparam t_cdc ATN = $signed({4'b0, ATAN_TAB[i]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[i+1] <= r_flip[i];
                if (r_cz[i] >= 0) begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] - ATN;
                end else begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] + ATN;
                end
            end
        end
    end

    // undo the half-turn fold and clamp
    assign fx = r_flip[CORDIC_STAGES] ? -r_cx[CORDIC_STAGES] : r_cx[CORDIC_STAGES];
    assign fy = r_flip[CORDIC_STAGES] ? -r_cy[CORDIC_STAGES] : r_cy[CORDIC_STAGES];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= clamp_q30(fx);
            r_sin <= clamp_q30(fy);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
`default_nettype wire

// File: rtl/core/great_circle_distance_top.sv
// Haversine great-circle distance, fully pipelined.
// Input channel: i_valid / o_ready with two points, latitude and longitude in
// signed degrees * 2^23. An item is taken on each edge with both high.
// Output channel: o_valid / i_ready with o_distance_km, unsigned km * 2^16,
// saturated at half the circumference.
// Pipeline: turn conversion, four parallel sine/cosine CORDIC lanes, three
// product stages, two 31-step square-root pipelines, the vectoring CORDIC and
// the scaling multiply.
// Throughput: one item per cycle; every stage is a register and a valid bit.
// When the output holds an item that is not taken, the whole pipeline freezes
// and o_ready drops in the same cycle; nothing is lost or repeated.
// Reset clears the valid bits only; nothing is kept between items.
`default_nettype none
module great_circle_distance_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [30:0] i_first_latitude,
    input  logic signed [31:0] i_first_longitude,
    input  logic signed [30:0] i_second_latitude,
    input  logic signed [31:0] i_second_longitude,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [30:0]        o_distance_km
);
    import gcd_pkg::*;

    `include "great_circle_distance_top_macros.svh"

    localparam int A_IDX = ROT_LAT + 3;

    logic               pipe_en;
    logic [PIPE_LAT-1:0] r_vld;

    logic signed [30:0] r_lat1, r_lat2;
    logic signed [31:0] r_lon1, r_lon2;
    t_turn_num          m_dlat, m_dlon, m_lat1, m_lat2;
    t_q30               slat, slon, c1, c2;

    t_q30               r_sl2, r_sn2, r_cc, r_sl2b, r_t;
    logic signed [32:0] a_sum;
    logic [30:0]        r_a, r_b;

    logic [60:0] r_sq_n [2][SQRT_STEPS];
    logic [61:0] r_sq_r [2][SQRT_STEPS];

    t_cdc r_vx [CORDIC_STAGES];
    t_cdc r_vy [CORDIC_STAGES];
    t_cdc r_vz [CORDIC_STAGES];

    logic [30:0] zc;
    logic [62:0] r_prod;
    logic [63:0] dsum;
    logic [32:0] dq;
    logic [30:0] r_dist;

    // global advance: stalls only when the output item is not taken
    assign pipe_en = !r_vld[PIPE_LAT-1] || i_ready;
    assign o_ready = pipe_en;
    assign o_valid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_lat1 <= i_first_latitude;
            r_lon1 <= i_first_longitude;
            r_lat2 <= i_second_latitude;
            r_lon2 <= i_second_longitude;
        end
    end

    // rounded numerators: half angles use 32*u + 22, full angles 64*u + 22
    assign m_dlat = ((40'(r_lat2) - 40'(r_lat1)) <<< 5) + 40'sd22;
    assign m_dlon = ((40'(r_lon2) - 40'(r_lon1)) <<< 5) + 40'sd22;
    assign m_lat1 = (40'(r_lat1) <<< 6) + 40'sd22;
    assign m_lat2 = (40'(r_lat2) <<< 6) + 40'sd22;

    gcd_rot u_rot_dlat (.i_clk(i_clk), .i_en(pipe_en), .i_num(m_dlat),
                        .o_sin(slat), .o_cos());
    gcd_rot u_rot_dlon (.i_clk(i_clk), .i_en(pipe_en), .i_num(m_dlon),
                        .o_sin(slon), .o_cos());
    gcd_rot u_rot_lat1 (.i_clk(i_clk), .i_en(pipe_en), .i_num(m_lat1),
                        .o_sin(), .o_cos(c1));
    gcd_rot u_rot_lat2 (.i_clk(i_clk), .i_en(pipe_en), .i_num(m_lat2),
                        .o_sin(), .o_cos(c2));

    // squares and cosine product
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_sl2 <= 32'((64'(slat) * 64'(slat)) >>> 30);
            r_sn2 <= 32'((64'(slon) * 64'(slon)) >>> 30);
            r_cc  <= 32'((64'(c1) * 64'(c2)) >>> 30);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_t    <= 32'((64'(r_cc) * 64'(r_sn2)) >>> 30);
            r_sl2b <= r_sl2;
        end
    end

    // a clamped to [0, 1], and its complement
    assign a_sum = 33'(r_sl2b) + 33'(r_t);
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            if (a_sum < 0) begin
                r_a <= '0;
                r_b <= 31'(ONE_Q30);
            end else if (a_sum > 33'(ONE_Q30)) begin
                r_a <= 31'(ONE_Q30);
                r_b <= '0;
            end else begin
                r_a <= 31'(a_sum);
                r_b <= 31'(ONE_Q30) - 31'(a_sum);
            end
        end
    end

    // digit-by-digit square roots of a and 1-a, one result bit per stage
    for (genvar j = 0; j < 2; j++) begin : g_sq
        for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_st
            localparam logic [61:0] BIT = 62'd1 << (2 * (SQRT_STEPS - 1 - k));
            logic [60:0] n_in;
            logic [61:0] r_in;
            logic [61:0] trial;
            if (k == 0) begin : g_first
                assign n_in = (j == 0) ? {r_a, 30'b0} : {r_b, 30'b0};
                assign r_in = '0;
            end else begin : g_next
                assign n_in = r_sq_n[j][k-1];
                assign r_in = r_sq_r[j][k-1];
            end
            assign trial = r_in + BIT;
            always_ff @(posedge i_clk) begin
                if (pipe_en) begin
                    if ({1'b0, n_in} >= trial) begin
                        r_sq_n[j][k] <= 61'({1'b0, n_in} - trial);
                        r_sq_r[j][k] <= (r_in >> 1) + BIT;
                    end else begin
                        r_sq_n[j][k] <= n_in;
                        r_sq_r[j][k] <= r_in >> 1;
                    end
                end
            end
        end
    end

    // vectoring CORDIC: angle of (sqrt(1-a), sqrt(a))
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
        localparam t_cdc ATN = $signed({4'b0, ATAN_TAB[i]});
        t_cdc x_in, y_in, z_in;
        if (i == 0) begin : g_first
            assign x_in = $signed({3'b0, r_sq_r[1][SQRT_STEPS-1][30:0]});
            assign y_in = $signed({3'b0, r_sq_r[0][SQRT_STEPS-1][30:0]});
            assign z_in = '0;
        end else begin : g_next
            assign x_in = r_vx[i-1];
            assign y_in = r_vy[i-1];
            assign z_in = r_vz[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                if (y_in > 0) begin
                    r_vx[i] <= x_in + (y_in >>> i);
                    r_vy[i] <= y_in - (x_in >>> i);
                    r_vz[i] <= z_in + ATN;
                end else begin
                    r_vx[i] <= x_in - (y_in >>> i);
                    r_vy[i] <= y_in + (x_in >>> i);
                    r_vz[i] <= z_in - ATN;
                end
            end
        end
    end

    // clamp to a quarter turn and scale by the circumference
    assign zc = (r_vz[CORDIC_STAGES-1] < 0) ? '0 :
                (r_vz[CORDIC_STAGES-1] > ONE_Q30) ? 31'(ONE_Q30) :
                31'(r_vz[CORDIC_STAGES-1]);
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_prod <= 63'(zc) * 63'(DIST_MULT);
        end
    end

    // round, saturate at half the circumference
    assign dsum = 64'(r_prod) + (64'd1 << 30);
    assign dq   = 33'(dsum >> 31);
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_dist <= (dq > 33'(DIST_MAX)) ? DIST_MAX : 31'(dq);
        end
    end

    assign o_distance_km = r_dist;

    `GCD_ASSERT_NOW(a_dist_sat, i_clk, i_rst_n, o_valid, o_distance_km <= DIST_MAX,
        "distance above half circumference")
    `GCD_ASSERT_NOW(a_stall_ready, i_clk, i_rst_n, o_valid && !i_ready, !o_ready,
        "input taken while output is stalled")
    `GCD_ASSERT_NEXT(a_freeze, i_clk, i_rst_n, !o_ready, $stable(r_vld),
        "pipeline moved during stall")
    `GCD_ASSERT_NOW(a_hav_range, i_clk, i_rst_n, r_vld[A_IDX],
        (r_a <= 31'(ONE_Q30)) && (31'(r_a + r_b) == 31'(ONE_Q30)),
        "haversine term out of range")

endmodule
`default_nettype wire
